### rtl/irpdt_pkg.sv
// ----------------------------------------------------------------------------
// irpdt_pkg
// Shared types and constants of the pulse-distance IR transmitter.
// ----------------------------------------------------------------------------
`default_nettype none

package irpdt_pkg;

  localparam int DEF_QUEUE_DEPTH = 32;
  localparam int DATA_W          = 8;
  localparam int KIND_W          = 2;
  localparam int CFG_IDX_W       = 3;
  localparam int LEVEL_W         = 6;

  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BURST      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_GAP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_GAP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POST_START = 3'd4;

  localparam logic [DATA_W-1:0] RST_BURST      = 8'd40;
  localparam logic [DATA_W-1:0] RST_ZERO_GAP   = 8'd47;
  localparam logic [DATA_W-1:0] RST_ONE_GAP    = 8'd124;
  localparam logic [DATA_W-1:0] RST_START      = 8'd255;
  localparam logic [DATA_W-1:0] RST_POST_START = 8'd200;
  localparam logic [DATA_W-1:0] IDLE_GAP       = 8'd255;

  localparam logic [2:0] PHASE_START = 3'd1;
  localparam logic [2:0] PHASE_BURST = 3'd5;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_WRITE,
    OP_FLUSH,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] data;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/irpdt_if.sv
// ----------------------------------------------------------------------------
// irpdt interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface irpdt_in_if;
  logic                              valid;
  logic                              ready;
  logic [irpdt_pkg::KIND_W-1:0]      kind;
  logic [irpdt_pkg::DATA_W-1:0]      data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface irpdt_out_if;
  logic                              valid;
  logic                              ready;
  logic                              carrier_on;
  logic [2:0]                        phase;
  logic [irpdt_pkg::LEVEL_W-1:0]     queue_level;
  logic                              write_dropped;
  logic                              frame_active;

  modport source (output valid, output carrier_on, output phase, output queue_level,
                  output write_dropped, output frame_active, input ready);
  modport sink   (input valid, input carrier_on, input phase, input queue_level,
                  input write_dropped, input frame_active, output ready);
endinterface

`default_nettype wire

### rtl/irpdt_front.sv
// ----------------------------------------------------------------------------
// irpdt_front
// Accepts input items, decodes the kind into a command and holds it in a
// two-entry command queue for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module irpdt_front (
  input  wire logic            clk,
  input  wire logic            rst,
  irpdt_in_if.sink             items,
  output irpdt_pkg::cmd_t      cmd,
  output logic                 cmd_valid,
  input  wire logic            cmd_ready
);

  irpdt_pkg::cmd_t q [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      cnt;
  irpdt_pkg::cmd_t decoded;
  logic            push;
  logic            pop;

  always_comb begin
    decoded.data = items.data_byte;
    case (items.kind)
      irpdt_pkg::KIND_TICK:  decoded.op = irpdt_pkg::OP_TICK;
      irpdt_pkg::KIND_WRITE: decoded.op = irpdt_pkg::OP_WRITE;
      irpdt_pkg::KIND_FLUSH: decoded.op = irpdt_pkg::OP_FLUSH;
      default:               decoded.op = irpdt_pkg::OP_NOP;
    endcase
  end

  assign items.ready = (cnt != 2'd2);
  assign push        = items.valid && items.ready;
  assign cmd_valid   = (cnt != 2'd0);
  assign pop         = cmd_valid && cmd_ready;
  assign cmd         = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/irpdt_engine.sv
// ----------------------------------------------------------------------------
// irpdt_engine
// Runs the commands: byte FIFO, tick counter and frame sequencer, with the
// duration registers and a registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module irpdt_engine #(
  parameter int QUEUE_DEPTH = irpdt_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire irpdt_pkg::cmd_t                   cmd,
  input  wire logic                              cmd_valid,
  output logic                                   cmd_ready,
  input  wire logic                              cfg_wr_en,
  input  wire logic [irpdt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [irpdt_pkg::DATA_W-1:0]      cfg_data,
  irpdt_out_if.source                            results
);

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QAW-1:0] LAST_ADDR = QAW'(QUEUE_DEPTH - 1);
  localparam logic [QCW-1:0] FULL_CNT  = QCW'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    PH_OFF   = 3'd0,
    PH_START = 3'd1,
    PH_POST  = 3'd2,
    PH_ZERO  = 3'd3,
    PH_ONE   = 3'd4,
    PH_BURST = 3'd5,
    PH_END   = 3'd6
  } phase_t;

  typedef struct packed {
    logic [irpdt_pkg::DATA_W-1:0] burst;
    logic [irpdt_pkg::DATA_W-1:0] zero_gap;
    logic [irpdt_pkg::DATA_W-1:0] one_gap;
    logic [irpdt_pkg::DATA_W-1:0] start;
    logic [irpdt_pkg::DATA_W-1:0] post_start;
  } cfg_t;

  typedef struct packed {
    logic                          carrier_on;
    logic [2:0]                    phase;
    logic [irpdt_pkg::LEVEL_W-1:0] queue_level;
    logic                          write_dropped;
    logic                          frame_active;
  } result_t;

  logic [irpdt_pkg::DATA_W-1:0] mem [QUEUE_DEPTH];
  logic [irpdt_pkg::DATA_W-1:0] rd_data;

  cfg_t         cfg;
  phase_t       phase, phase_next;
  logic [7:0]   tick_count, tick_count_next;
  logic         carrier, carrier_next;
  logic         complete, complete_next;
  logic [2:0]   bit_index, bit_index_next;
  logic [7:0]   shift_byte, shift_byte_next;
  logic [QAW-1:0] head, head_next, tail, tail_next;
  logic [QCW-1:0] count, count_next;
  logic         dropped;
  logic         mem_we;
  logic         exec;
  logic         res_valid;
  result_t      res;
  logic [QCW+irpdt_pkg::LEVEL_W-1:0] level_ext;

  assign cmd_ready = !res_valid || results.ready;
  assign exec      = cmd_valid && cmd_ready;

  always_comb begin
    phase_t sym;
    logic   bit_val;
    phase_next      = phase;
    tick_count_next = tick_count;
    carrier_next    = carrier;
    complete_next   = complete;
    bit_index_next  = bit_index;
    shift_byte_next = shift_byte;
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    dropped         = 1'b0;
    mem_we          = 1'b0;
    sym             = PH_OFF;
    bit_val         = 1'b0;
    if (exec) begin
      case (cmd.op)
        irpdt_pkg::OP_TICK: begin
          if (tick_count != 8'd0) begin
            tick_count_next = tick_count - 8'd1;
          end else begin
            case (phase)
              PH_POST, PH_ZERO, PH_ONE: begin
                phase_next      = PH_BURST;
                carrier_next    = 1'b1;
                tick_count_next = cfg.burst;
              end
              PH_BURST, PH_OFF: begin
                if (complete) begin
                  if (count == '0) begin
                    sym = PH_OFF;
                  end else begin
                    complete_next  = 1'b0;
                    bit_index_next = 3'd0;
                    sym            = PH_START;
                  end
                end else if (bit_index != 3'd0) begin
                  bit_index_next = bit_index - 3'd1;
                  bit_val        = shift_byte[bit_index_next];
                  sym            = bit_val ? PH_ONE : PH_ZERO;
                end else if (count != '0) begin
                  shift_byte_next = rd_data;
                  bit_index_next  = 3'd7;
                  head_next       = (head == LAST_ADDR) ? '0 : head + 1'b1;
                  count_next      = count - 1'b1;
                  bit_val         = rd_data[7];
                  sym             = bit_val ? PH_ONE : PH_ZERO;
                end else begin
                  complete_next = 1'b1;
                  sym           = PH_END;
                end
                phase_next = sym;
                case (sym)
                  PH_ZERO: begin
                    tick_count_next = cfg.zero_gap;
                    carrier_next    = 1'b0;
                  end
                  PH_ONE: begin
                    tick_count_next = cfg.one_gap;
                    carrier_next    = 1'b0;
                  end
                  PH_START: begin
                    tick_count_next = cfg.start;
                    carrier_next    = 1'b1;
                  end
                  default: begin
                    tick_count_next = irpdt_pkg::IDLE_GAP;
                    carrier_next    = 1'b0;
                  end
                endcase
              end
              PH_START, PH_END: begin
                carrier_next    = 1'b0;
                tick_count_next = cfg.post_start;
                phase_next      = (phase == PH_START) ? PH_POST : PH_OFF;
              end
              default: begin
              end
            endcase
          end
        end
        irpdt_pkg::OP_WRITE: begin
          if (count >= FULL_CNT) begin
            dropped = 1'b1;
          end else begin
            mem_we     = 1'b1;
            tail_next  = (tail == LAST_ADDR) ? '0 : tail + 1'b1;
            count_next = count + 1'b1;
          end
        end
        irpdt_pkg::OP_FLUSH: begin
          head_next     = '0;
          tail_next     = '0;
          count_next    = '0;
          complete_next = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign level_ext = {{irpdt_pkg::LEVEL_W{1'b0}}, count_next};

  // memory with head prefetch; a write landing on the next head is forwarded
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail] <= cmd.data;
    end
    if (mem_we && (tail == head_next)) begin
      rd_data <= cmd.data;
    end else begin
      rd_data <= mem[head_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.burst      <= irpdt_pkg::RST_BURST;
      cfg.zero_gap   <= irpdt_pkg::RST_ZERO_GAP;
      cfg.one_gap    <= irpdt_pkg::RST_ONE_GAP;
      cfg.start      <= irpdt_pkg::RST_START;
      cfg.post_start <= irpdt_pkg::RST_POST_START;
      phase          <= PH_OFF;
      tick_count     <= 8'd0;
      carrier        <= 1'b0;
      complete       <= 1'b1;
      bit_index      <= 3'd0;
      shift_byte     <= 8'd0;
      head           <= '0;
      tail           <= '0;
      count          <= '0;
      res_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          irpdt_pkg::REG_BURST:      cfg.burst      <= cfg_data;
          irpdt_pkg::REG_ZERO_GAP:   cfg.zero_gap   <= cfg_data;
          irpdt_pkg::REG_ONE_GAP:    cfg.one_gap    <= cfg_data;
          irpdt_pkg::REG_START:      cfg.start      <= cfg_data;
          irpdt_pkg::REG_POST_START: cfg.post_start <= cfg_data;
          default: begin
          end
        endcase
      end
      phase      <= phase_next;
      tick_count <= tick_count_next;
      carrier    <= carrier_next;
      complete   <= complete_next;
      bit_index  <= bit_index_next;
      shift_byte <= shift_byte_next;
      head       <= head_next;
      tail       <= tail_next;
      count      <= count_next;
      if (exec) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
    if (exec) begin
      res.carrier_on    <= carrier_next;
      res.phase         <= phase_next;
      res.queue_level   <= level_ext[irpdt_pkg::LEVEL_W-1:0];
      res.write_dropped <= dropped;
      res.frame_active  <= !complete_next;
    end
  end

  assign results.valid         = res_valid;
  assign results.carrier_on    = res.carrier_on;
  assign results.phase         = res.phase;
  assign results.queue_level   = res.queue_level;
  assign results.write_dropped = res.write_dropped;
  assign results.frame_active  = res.frame_active;

endmodule

`default_nettype wire

### rtl/ir_pulse_distance_transmitter_unit.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_transmitter_unit
// Tick-driven pulse-distance IR transmitter with a byte FIFO.
//
//   channel   dir  handshake               payload
//   items     in   valid/ready             kind, data_byte
//   results   out  valid/ready             carrier_on, phase, queue_level,
//                                          write_dropped, frame_active
//   config    in   cfg_wr_en (no stall)    cfg_index, cfg_data
//
// One item per clock sustained while results are taken; a result passes the
// command queue stage, then the engine's result register, after its input transfer.
// The engine's single update path sets the rate: one command per unstalled cycle.
// Reset is synchronous; no clearing pass, the FIFO store is read only after
// being written.
// A stalled result holds the engine; the two-entry command queue keeps the
// input accepting until it holds two items.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pulse_distance_transmitter_unit #(
  parameter int QUEUE_DEPTH = irpdt_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  irpdt_in_if.sink                               items,
  irpdt_out_if.source                            results,
  input  wire logic                              cfg_wr_en,
  input  wire logic [irpdt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [irpdt_pkg::DATA_W-1:0]      cfg_data
);

  irpdt_pkg::cmd_t cmd;
  logic            cmd_valid;
  logic            cmd_ready;

  irpdt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  irpdt_engine #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .results   (results)
  );

endmodule

`default_nettype wire

### rtl/irpdt_checker.sv
// ----------------------------------------------------------------------------
// irpdt_checker
// Port-level checks of the IR transmitter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module irpdt_checker #(
  parameter int QUEUE_DEPTH = irpdt_pkg::DEF_QUEUE_DEPTH
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          carrier_on,
  input wire logic [2:0]                    phase,
  input wire logic [irpdt_pkg::LEVEL_W-1:0] queue_level,
  input wire logic                          write_dropped,
  input wire logic                          frame_active
);

  localparam logic [irpdt_pkg::LEVEL_W-1:0] FULL_LEVEL =
    irpdt_pkg::LEVEL_W'(QUEUE_DEPTH % 64);

  logic [2:0] pending;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 3'd0;
    end else begin
      pending <= pending + {2'b0, in_xfer} - {2'b0, out_xfer};
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(carrier_on) && $stable(phase)
      && $stable(queue_level) && $stable(write_dropped) && $stable(frame_active))
    else $error("result changed while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0)
    else $error("result without a pending transfer");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd3)
    else $error("more items in flight than storage allows");

  a_carrier: assert property (@(posedge clk) disable iff (rst)
    out_valid && carrier_on |->
      phase == irpdt_pkg::PHASE_START || phase == irpdt_pkg::PHASE_BURST)
    else $error("carrier on outside a burst");

  a_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_dropped |-> queue_level == FULL_LEVEL)
    else $error("write dropped with room in the FIFO");

endmodule

bind ir_pulse_distance_transmitter_unit irpdt_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_irpdt_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (items.valid),
  .in_ready      (items.ready),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .carrier_on    (results.carrier_on),
  .phase         (results.phase),
  .queue_level   (results.queue_level),
  .write_dropped (results.write_dropped),
  .frame_active  (results.frame_active)
);

`default_nettype wire

### dv/ir_pulse_distance_transmitter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_distance_transmitter_unit_tb
// Self-checking bench for the IR pulse-distance transmitter. An item-level
// frame tracker mirrors the FIFO, tick counter and phase sequencing, and
// every result transfer is compared field by field against it. Stimulus is a
// short directed run followed by random write, tick and flush sequences
// under several duration settings, with bursty input and a stalling sink.
// ----------------------------------------------------------------------------
module ir_pulse_distance_transmitter_unit_tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int QD           = irpdt_pkg::DEF_QUEUE_DEPTH;
  localparam int DW           = irpdt_pkg::DATA_W;
  localparam int IW           = irpdt_pkg::CFG_IDX_W;
  localparam int LW           = irpdt_pkg::LEVEL_W;
  localparam logic [IW-1:0] REG_SPARE = 3'd7;

  typedef enum logic [2:0] {
    SEG_OFF,
    SEG_START,
    SEG_LEAD_GAP,
    SEG_ZERO_GAP,
    SEG_ONE_GAP,
    SEG_BURST,
    SEG_END
  } ir_seg_t;

  typedef struct packed {
    logic          carrier_on;
    logic [2:0]    phase;
    logic [LW-1:0] queue_level;
    logic          write_dropped;
    logic          frame_active;
  } ir_status_t;

  class ir_frame_checker;
    logic [DW-1:0] burst_len, zero_gap_len, one_gap_len, start_len, post_len;
    ir_seg_t       seg;
    logic [7:0]    ticks_left;
    logic          carrier;
    logic          complete;
    logic [2:0]    bit_pos;
    logic [DW-1:0] shifter;
    logic [DW-1:0] fifo_mem [QD];
    int unsigned   rd_ptr, wr_ptr, fill;
    ir_status_t    expected_status_q [$];
    int            errors;

    function new();
      burst_len    = irpdt_pkg::RST_BURST;
      zero_gap_len = irpdt_pkg::RST_ZERO_GAP;
      one_gap_len  = irpdt_pkg::RST_ONE_GAP;
      start_len    = irpdt_pkg::RST_START;
      post_len     = irpdt_pkg::RST_POST_START;
      seg          = SEG_OFF;
      ticks_left   = '0;
      carrier      = 1'b0;
      complete     = 1'b1;
      bit_pos      = '0;
      shifter      = '0;
      rd_ptr       = 0;
      wr_ptr       = 0;
      fill         = 0;
      errors       = 0;
    endfunction

    function void set_reg(logic [IW-1:0] idx, logic [DW-1:0] val);
      case (idx)
        irpdt_pkg::REG_BURST:      burst_len = val;
        irpdt_pkg::REG_ZERO_GAP:   zero_gap_len = val;
        irpdt_pkg::REG_ONE_GAP:    one_gap_len = val;
        irpdt_pkg::REG_START:      start_len = val;
        irpdt_pkg::REG_POST_START: post_len = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_status_q.size();
    endfunction

    function void note_item(irpdt_pkg::op_t op, logic [DW-1:0] data);
      ir_seg_t    nxt;
      ir_status_t st;
      st.write_dropped = 1'b0;
      case (op)
        irpdt_pkg::OP_TICK: begin
          if (ticks_left != 0) begin
            ticks_left--;
          end else begin
            case (seg)
              SEG_LEAD_GAP, SEG_ZERO_GAP, SEG_ONE_GAP: begin
                seg        = SEG_BURST;
                carrier    = 1'b1;
                ticks_left = burst_len;
              end
              SEG_BURST, SEG_OFF: begin
                if (complete) begin
                  nxt = SEG_OFF;
                  if (fill != 0) begin
                    complete = 1'b0;
                    bit_pos  = '0;
                    nxt      = SEG_START;
                  end
                end else begin
                  if (bit_pos != 0) begin
                    bit_pos--;
                  end else if (fill != 0) begin
                    shifter = fifo_mem[rd_ptr];
                    rd_ptr  = (rd_ptr + 1) % QD;
                    fill--;
                    bit_pos = 3'd7;
                  end else begin
                    complete = 1'b1;
                  end
                  if (complete) nxt = SEG_END;
                  else nxt = shifter[bit_pos] ? SEG_ONE_GAP : SEG_ZERO_GAP;
                end
                seg = nxt;
                case (nxt)
                  SEG_ZERO_GAP: begin
                    ticks_left = zero_gap_len;
                    carrier    = 1'b0;
                  end
                  SEG_ONE_GAP: begin
                    ticks_left = one_gap_len;
                    carrier    = 1'b0;
                  end
                  SEG_START: begin
                    ticks_left = start_len;
                    carrier    = 1'b1;
                  end
                  default: begin
                    ticks_left = irpdt_pkg::IDLE_GAP;
                    carrier    = 1'b0;
                  end
                endcase
              end
              SEG_START, SEG_END: begin
                carrier    = 1'b0;
                ticks_left = post_len;
                seg        = (seg == SEG_START) ? SEG_LEAD_GAP : SEG_OFF;
              end
              default: ;
            endcase
          end
        end
        irpdt_pkg::OP_WRITE: begin
          if (fill >= QD) begin
            st.write_dropped = 1'b1;
          end else begin
            fifo_mem[wr_ptr] = data;
            wr_ptr = (wr_ptr + 1) % QD;
            fill++;
          end
        end
        irpdt_pkg::OP_FLUSH: begin
          rd_ptr   = 0;
          wr_ptr   = 0;
          fill     = 0;
          complete = 1'b1;
        end
        default: ;
      endcase
      st.carrier_on   = carrier;
      st.phase        = seg;
      st.queue_level  = LW'(fill);
      st.frame_active = !complete;
      expected_status_q.push_back(st);
    endfunction

    function void check_result(ir_status_t got);
      ir_status_t want;
      if (expected_status_q.size() == 0) begin
        $error("result transfer with no expected status (phase %0d)", got.phase);
        errors++;
        return;
      end
      want = expected_status_q.pop_front();
      if (got.carrier_on !== want.carrier_on) begin
        $error("carrier_on: expected %0d, got %0d", want.carrier_on, got.carrier_on);
        errors++;
      end
      if (got.phase !== want.phase) begin
        $error("phase: expected %0d, got %0d", want.phase, got.phase);
        errors++;
      end
      if (got.queue_level !== want.queue_level) begin
        $error("queue_level: expected %0d, got %0d", want.queue_level, got.queue_level);
        errors++;
      end
      if (got.write_dropped !== want.write_dropped) begin
        $error("write_dropped: expected %0d, got %0d", want.write_dropped,
               got.write_dropped);
        errors++;
      end
      if (got.frame_active !== want.frame_active) begin
        $error("frame_active: expected %0d, got %0d", want.frame_active, got.frame_active);
        errors++;
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst;
  logic          cfg_wr_en;
  logic [IW-1:0] cfg_index;
  logic [DW-1:0] cfg_data;

  irpdt_in_if  items_if ();
  irpdt_out_if results_if ();

  ir_frame_checker frame_checker = new();

  int burst_left;
  bit hold_request;
  int cycle_count = 0;

  ir_pulse_distance_transmitter_unit #(
    .QUEUE_DEPTH(QD)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .items     (items_if),
    .results   (results_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (results_if.valid && results_if.ready) begin
        frame_checker.check_result(ir_status_t'{
          carrier_on:    results_if.carrier_on,
          phase:         results_if.phase,
          queue_level:   results_if.queue_level,
          write_dropped: results_if.write_dropped,
          frame_active:  results_if.frame_active});
      end
      if (items_if.valid && items_if.ready) begin
        frame_checker.note_item(irpdt_pkg::op_t'(items_if.kind), items_if.data_byte);
      end
    end
  end

  // sink stall pattern; a long hold-off lets the command queue back up
  initial begin : result_sink
    int hold_left;
    int mode_left;
    int mode;
    int beat;
    hold_left = 0;
    mode_left = 0;
    mode      = 0;
    beat      = 0;
    results_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      beat++;
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        results_if.ready <= 1'b0;
      end else begin
        case (mode)
          0:       results_if.ready <= 1'b1;
          1:       results_if.ready <= ($urandom_range(0, 3) != 0);
          2:       results_if.ready <= beat[0];
          default: results_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_item(irpdt_pkg::op_t op, logic [DW-1:0] d);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        items_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    items_if.valid     <= 1'b1;
    items_if.kind      <= op;
    items_if.data_byte <= d;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
  endtask

  task automatic send_run(irpdt_pkg::op_t op, int count);
    repeat (count) send_item(op, 8'($urandom_range(0, 255)));
  endtask

  task automatic write_reg(logic [IW-1:0] idx, logic [DW-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    frame_checker.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic program_regs(logic [DW-1:0] burst, logic [DW-1:0] zero_gap,
                              logic [DW-1:0] one_gap, logic [DW-1:0] start,
                              logic [DW-1:0] post_start);
    write_reg(irpdt_pkg::REG_BURST, burst);
    write_reg(irpdt_pkg::REG_ZERO_GAP, zero_gap);
    write_reg(irpdt_pkg::REG_ONE_GAP, one_gap);
    write_reg(irpdt_pkg::REG_START, start);
    write_reg(irpdt_pkg::REG_POST_START, post_start);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic settle();
    items_if.valid <= 1'b0;
    while (frame_checker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly tick runs and short write runs; occasional FIFO fills, flushes, unused kind
  task automatic run_random(int n, int write_pct);
    int sent;
    int r;
    int len;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < write_pct) begin
        len = $urandom_range(1, 5);
        send_run(irpdt_pkg::OP_WRITE, len);
        sent += len;
      end else if (r < write_pct + 2) begin
        len = $urandom_range(QD / 2, QD + 4);
        send_run(irpdt_pkg::OP_WRITE, len);
        sent += len;
      end else if (r < write_pct + 5) begin
        send_item(irpdt_pkg::OP_FLUSH, 8'($urandom_range(0, 255)));
        sent++;
      end else if (r < write_pct + 8) begin
        send_item(irpdt_pkg::OP_NOP, 8'($urandom_range(0, 255)));
      end else begin
        len = $urandom_range(1, 30);
        send_run(irpdt_pkg::OP_TICK, len);
        sent += len;
      end
    end
  endtask

  initial begin
    rst                <= 1'b1;
    cfg_wr_en          <= 1'b0;
    cfg_index          <= irpdt_pkg::REG_BURST;
    cfg_data           <= '0;
    items_if.valid     <= 1'b0;
    items_if.kind      <= irpdt_pkg::OP_TICK;
    items_if.data_byte <= '0;
    burst_left   = 0;
    hold_request = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset durations: unused kind, data extremes, frame start, flush mid-frame
    send_item(irpdt_pkg::OP_NOP, 8'hFF);
    send_item(irpdt_pkg::OP_WRITE, 8'h00);
    send_item(irpdt_pkg::OP_WRITE, 8'hFF);
    send_item(irpdt_pkg::OP_TICK, 8'h00);
    send_item(irpdt_pkg::OP_WRITE, 8'h80);
    send_item(irpdt_pkg::OP_WRITE, 8'h7F);
    send_run(irpdt_pkg::OP_TICK, 3);
    send_item(irpdt_pkg::OP_FLUSH, 8'h00);
    send_item(irpdt_pkg::OP_NOP, 8'h00);
    send_item(irpdt_pkg::OP_TICK, 8'hFF);
    send_item(irpdt_pkg::OP_WRITE, 8'h55);
    send_item(irpdt_pkg::OP_FLUSH, 8'hAA);
    send_run(irpdt_pkg::OP_TICK, 2);
    settle();

    // zero durations, out-of-range index, FIFO overfill
    write_reg(REG_SPARE, 8'hFF);
    program_regs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_run(irpdt_pkg::OP_WRITE, QD + 2);
    hold_request = 1'b1;
    run_random(150, 15);
    settle();

    program_regs(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                 8'($urandom_range(0, 3)));
    run_random(180, 20);
    settle();

    program_regs(8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
                 8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
                 8'($urandom_range(0, 15)));
    hold_request = 1'b1;
    run_random(180, 10);
    settle();

    program_regs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    run_random(140, 5);
    settle();

    program_regs(8'd0, 8'd1, 8'd255, 8'd0, 8'd255);
    run_random(100, 25);
    settle();

    program_regs(8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)),
                 8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)),
                 8'($urandom_range(0, 7)));
    run_random(100, 6);
    settle();

    if (frame_checker.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
